FILE: hdl/fpcb_pkg.sv
package fpcb_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 12'd1200;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 12'd800;

  // x/5 == (x*3277) >> 14 for every x below 2^11
  localparam logic [11:0] DIV5_MUL   = 12'd3277;
  localparam int          DIV5_SHIFT = 14;

  typedef struct packed {
    logic             operation;
    logic [PIX_W-1:0] pixel_value;
  } in_word_t;

  typedef struct packed {
    logic [PIX_W-1:0] blurred_value;
    logic             frame_last;
  } out_word_t;

  typedef struct packed {
    logic adv;   // stream position moves, taps shift
    logic emit;  // item releases one result
    logic filt;  // result is the cross mean, else a copy
    logic last;  // final result of the frame
  } ctl_t;

  function automatic logic [PIX_W-1:0] div5(input logic [SUM_W-1:0] s);
    logic [SUM_W+11:0] p;
    p = (SUM_W+12)'(s) * (SUM_W+12)'(DIV5_MUL);
    return p[DIV5_SHIFT +: PIX_W];
  endfunction

endpackage

FILE: hdl/fpcb_line_mem.sv
module fpcb_line_mem
  import fpcb_pkg::*;
#(
  parameter int AW = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [PIX_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_d,
  output logic [PIX_W-1:0] rd_a_r,
  output logic [PIX_W-1:0] rd_d_r
);

  logic [PIX_W-1:0] mem [2**AW];

  // read returns the old contents when read and write hit the same entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_d_r <= mem[rd_addr_d];
    end
  end

endmodule

FILE: hdl/fpcb_ctrl.sv
module fpcb_ctrl
  import fpcb_pkg::*;
#(
  parameter  int MAX_WIDTH = 2048,
  localparam int CW        = $clog2(MAX_WIDTH),
  localparam int AW        = $clog2(2 * MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_acc,
  input  logic                  operation,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output ctl_t                  ctl,
  output logic                  wr_en,
  output logic [AW-1:0]         wp,
  output logic [AW-1:0]         rd_addr_a,
  output logic [AW-1:0]         rd_addr_d
);

  function automatic logic [CW-1:0] sat_wm1(input logic [CFG_DATA_W-1:0] d);
    logic [CW-1:0] r;
    if (d < CFG_DATA_W'(3)) begin
      r = CW'(2);
    end else if (32'(d) > 32'(MAX_WIDTH)) begin
      r = CW'(MAX_WIDTH - 1);
    end else begin
      r = CW'(d - CFG_DATA_W'(1));
    end
    return r;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] sat_hm1(input logic [CFG_DATA_W-1:0] d);
    logic [CFG_DATA_W-1:0] r;
    if (d < CFG_DATA_W'(3)) begin
      r = CFG_DATA_W'(2);
    end else begin
      r = d - CFG_DATA_W'(1);
    end
    return r;
  endfunction

  logic [CW-1:0]         wm1_r, wm1_nxt;
  logic [CFG_DATA_W-1:0] hm1_r, hm1_nxt;
  logic [CW-1:0]         rcol_r, rcol_nxt;
  logic [CFG_DATA_W-1:0] rrow_r, rrow_nxt;
  logic                  all_in_r, all_in_nxt;
  logic [CW-1:0]         ecol_r, ecol_nxt;
  logic [CFG_DATA_W-1:0] erow_r, erow_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;

  always_comb begin
    ctl = '0;
    if (operation == OP_PIXEL) begin
      if (!all_in_r) begin
        ctl.adv  = 1'b1;
        ctl.emit = (rrow_r != '0);
        ctl.filt = (rrow_r != '0) && (erow_r != '0) && (erow_r != hm1_r);
      end
    end else begin
      // drain only once the frame is in; the pending row is the last one
      if (all_in_r) begin
        ctl.adv  = 1'b1;
        ctl.emit = 1'b1;
        ctl.last = (ecol_r == wm1_r);
      end
    end
  end

  always_comb begin
    wm1_nxt    = wm1_r;
    hm1_nxt    = hm1_r;
    rcol_nxt   = rcol_r;
    rrow_nxt   = rrow_r;
    all_in_nxt = all_in_r;
    ecol_nxt   = ecol_r;
    erow_nxt   = erow_r;
    wp_nxt     = wp_r;
    if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        wm1_nxt = sat_wm1(cfg_data);
      end else begin
        hm1_nxt = sat_hm1(cfg_data);
      end
      rcol_nxt   = '0;
      rrow_nxt   = '0;
      all_in_nxt = 1'b0;
      ecol_nxt   = '0;
      erow_nxt   = '0;
    end else if (in_acc) begin
      if (ctl.adv) begin
        wp_nxt = wp_r + AW'(1);
      end
      if (ctl.adv && operation == OP_PIXEL) begin
        if (rcol_r == wm1_r) begin
          rcol_nxt = '0;
          if (rrow_r == hm1_r) begin
            all_in_nxt = 1'b1;
          end else begin
            rrow_nxt = rrow_r + CFG_DATA_W'(1);
          end
        end else begin
          rcol_nxt = rcol_r + CW'(1);
        end
      end
      if (ctl.emit) begin
        if (ctl.last) begin
          rcol_nxt   = '0;
          rrow_nxt   = '0;
          all_in_nxt = 1'b0;
          ecol_nxt   = '0;
          erow_nxt   = '0;
        end else if (ecol_r == wm1_r) begin
          ecol_nxt = '0;
          erow_nxt = erow_r + CFG_DATA_W'(1);
        end else begin
          ecol_nxt = ecol_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wm1_r    <= sat_wm1(FRAME_WIDTH_RST);
      hm1_r    <= sat_hm1(FRAME_HEIGHT_RST);
      rcol_r   <= '0;
      rrow_r   <= '0;
      all_in_r <= 1'b0;
      ecol_r   <= '0;
      erow_r   <= '0;
      wp_r     <= '0;
    end else begin
      wm1_r    <= wm1_nxt;
      hm1_r    <= hm1_nxt;
      rcol_r   <= rcol_nxt;
      rrow_r   <= rrow_nxt;
      all_in_r <= all_in_nxt;
      ecol_r   <= ecol_nxt;
      erow_r   <= erow_nxt;
      wp_r     <= wp_nxt;
    end
  end

  // stream position v sits at wp; read x[v-w+1] and x[v-2w]
  assign wr_en     = in_acc && ctl.adv && (operation == OP_PIXEL);
  assign wp        = wp_r;
  assign rd_addr_a = wp_r - AW'(wm1_r);
  assign rd_addr_d = wp_r - AW'({wm1_r, 1'b0}) - AW'(2);

endmodule

FILE: hdl/fpcb_filter.sv
module fpcb_filter
  import fpcb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_acc,
  input  ctl_t             ctl_in,
  input  logic [PIX_W-1:0] pix_in,
  input  logic [PIX_W-1:0] rd_a,
  input  logic [PIX_W-1:0] rd_d,
  input  logic             out_stall,
  output logic             out_valid,
  output out_word_t        out_data,
  output logic             s1_valid,
  output ctl_t             s1_ctl,
  output logic             s1_go
);

  logic             s1_valid_r, s1_valid_nxt;
  ctl_t             s1_ctl_r;
  logic [PIX_W-1:0] s1_pix_r;
  logic [PIX_W-1:0] tap_b_r;   // x[p]
  logic [PIX_W-1:0] tap_c_r;   // x[p-1]
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r;
  logic             out_free;
  logic             s1_move;
  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] value;

  always_comb begin
    out_free = !out_valid_r || !out_stall;
    s1_go    = !s1_ctl_r.emit || out_free;
    s1_move  = s1_valid_r && s1_go;
    sum = SUM_W'(rd_d) + SUM_W'(tap_c_r) + SUM_W'(tap_b_r) + SUM_W'(rd_a)
        + SUM_W'(s1_pix_r);
    value = s1_ctl_r.filt ? div5(sum) : tap_b_r;

    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (s1_move && s1_ctl_r.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      s1_ctl_r <= ctl_in;
      s1_pix_r <= pix_in;
    end
    if (s1_move && s1_ctl_r.adv) begin
      tap_b_r <= rd_a;
      tap_c_r <= tap_b_r;
    end
    if (s1_move && s1_ctl_r.emit) begin
      out_data_r.blurred_value <= value;
      out_data_r.frame_last    <= s1_ctl_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign s1_valid  = s1_valid_r;
  assign s1_ctl    = s1_ctl_r;

endmodule

FILE: hdl/five_point_cross_blur_top.sv
// channel  | handshake              | word
// ---------+------------------------+--------------------------------------
// in       | in_valid / in_stall    | in_data   (operation, pixel_value)
// out      | out_valid / out_stall  | out_data  (blurred_value, frame_last)
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data (width, height)
//
// One word per clock while in_stall is low; a result reaches the output register
// after the line-buffer read, then the adder and divide-by-5 multiply.
// Results trail pixels by one row; drain words release the last row.
// Synchronous active-low reset clears counters and valids; the line buffer
// is not cleared and needs no sweep. cfg_ready is always high.
// in_stall rises only while a result-bearing word waits on a stalled output.
module five_point_cross_blur_top
  import fpcb_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(2 * MAX_WIDTH);

  logic             in_acc;
  logic             cfg_we;
  ctl_t             ctl;
  logic             wr_en;
  logic [AW-1:0]    wp;
  logic [AW-1:0]    rd_addr_a;
  logic [AW-1:0]    rd_addr_d;
  logic [PIX_W-1:0] rd_a;
  logic [PIX_W-1:0] rd_d;
  logic             s1_valid;
  ctl_t             s1_ctl;
  logic             s1_go;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = s1_valid && !s1_go;
  assign in_acc    = in_valid && !in_stall;

  fpcb_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .operation (in_data.operation),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctl       (ctl),
    .wr_en     (wr_en),
    .wp        (wp),
    .rd_addr_a (rd_addr_a),
    .rd_addr_d (rd_addr_d)
  );

  fpcb_line_mem #(
    .AW (AW)
  ) u_line_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wp),
    .wr_data   (in_data.pixel_value),
    .rd_en     (in_acc),
    .rd_addr_a (rd_addr_a),
    .rd_addr_d (rd_addr_d),
    .rd_a_r    (rd_a),
    .rd_d_r    (rd_d)
  );

  fpcb_filter u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .ctl_in    (ctl),
    .pix_in    (in_data.pixel_value),
    .rd_a      (rd_a),
    .rd_d      (rd_d),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .s1_valid  (s1_valid),
    .s1_ctl    (s1_ctl),
    .s1_go     (s1_go)
  );

  // a new result appears only behind a result-bearing word in the stage
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid && s1_ctl.emit))
    else $error("result without a result-bearing word");

  // the line buffer position moves only on accepted advancing words
  a_wp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && ctl.adv) |=> $stable(wp))
    else $error("write pointer moved without an advancing word");

  // the frame end is always a copied pixel that is emitted
  a_last_copy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && ctl.last) |-> (ctl.emit && ctl.adv && !ctl.filt))
    else $error("frame end on a filtered or silent word");

  // only words that give a result can hold the input side
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_ctl.emit && out_valid && out_stall))
    else $error("input stalled without a blocked result");

endmodule
